FILE: hw/rtl/vpt_pkg.sv
// Shared types and constants for the VPIN toxicity tracker.
`default_nettype none

package vpt_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned QTY_W   = 32;
  localparam int unsigned PRICE_W = 48;
  localparam int unsigned VPIN_W  = 14;
  localparam int unsigned MULT_W  = 15;
  localparam int unsigned CFG_W   = 14;
  localparam int unsigned CFG_IDX_W = 2;

  // Fixed-point scale and register reset values.
  localparam logic [VPIN_W-1:0] SCALE_14  = 14'd10000;
  localparam logic [MULT_W-1:0] SCALE_15  = 15'd10000;
  localparam logic [MULT_W-1:0] MULT_MAX  = 15'd20000;
  localparam logic [CFG_W-1:0]  THR_RST   = 14'd8000;
  localparam logic [CFG_W-1:0]  ALPHA_RST = 14'd500;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_ALPHA     = 2'd2
  } cfg_idx_t;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic              enable;
    logic [CFG_W-1:0]  threshold;
    logic [CFG_W-1:0]  alpha;
  } vpt_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic evict;
    logic add;
    logic diff;
    logic scale;
    logic div_start;
    logic take_vpin;
    logic num2;
    logic ema_start;
    logic load_out;
  } vpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_idle;
    logic ema_idle;
    logic toxic;
  } vpt_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/vpt_div.sv
// Restoring divider that yields a 14-bit quotient, one bit per cycle.
`default_nettype none

module vpt_div #(
  parameter int unsigned NW = 54,
  parameter int unsigned DW = 40
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [NW-1:0]               num,
  input  wire logic [DW-1:0]               den,
  output logic                             busy,
  output logic [vpt_pkg::VPIN_W-1:0]       quot
);
  import vpt_pkg::*;

  localparam int unsigned QW    = VPIN_W;
  localparam int unsigned CNT_W = $clog2(QW);
  localparam int unsigned SH_W  = DW + QW - 1;

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NW-1:0]    rem_r;
  logic [SH_W-1:0]  dsh_r;
  logic [QW-1:0]    q_r;
  logic [NW-1:0]    dsh_ext;
  logic             ge;

  // The quotient is known to fit in QW bits, so the divisor starts shifted
  // by QW-1 places and moves right by one each step.
  assign dsh_ext = NW'(dsh_r);
  assign ge      = (rem_r >= dsh_ext);

  // Iteration control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(QW - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Remainder, shifted divisor and quotient bits.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= {den, {(QW-1){1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_ext;
      end
      dsh_r <= dsh_r >> 1;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

`default_nettype wire

FILE: hw/rtl/vpt_ema.sv
// Volatility EMA of the absolute price change with a constant divide by 10000.
`default_nettype none

module vpt_ema (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [vpt_pkg::PRICE_W-1:0]   price,
  input  wire logic [vpt_pkg::CFG_W-1:0]     alpha,
  output logic                               busy,
  output logic [vpt_pkg::PRICE_W-1:0]        vol
);
  import vpt_pkg::*;

  localparam int unsigned PROD_W = PRICE_W + CFG_W;   // 62
  localparam int unsigned SH_W   = 64;
  localparam int unsigned DIG    = 4;                 // bits per divide step
  localparam int unsigned STEPS  = SH_W / DIG;
  localparam int unsigned CNT_W  = $clog2(STEPS);

  typedef enum logic [2:0] {
    E_IDLE,
    E_MUL_A,
    E_MUL_B,
    E_SUM,
    E_DIV
  } ema_state_t;

  ema_state_t          state_r;
  logic [PRICE_W-1:0]  prev_r;
  logic [PRICE_W-1:0]  vol_r;
  logic [PRICE_W-1:0]  delta_r;
  logic [CFG_W-1:0]    alpha_r;
  logic [CFG_W-1:0]    beta_r;
  logic [PROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]   acc_r;
  logic [SH_W-1:0]     sh_r;
  logic [VPIN_W-1:0]   rem_r;
  logic [PRICE_W-1:0]  quo_r;
  logic [CNT_W-1:0]    cnt_r;

  logic [CFG_W-1:0]    alpha_sat;
  logic [PRICE_W-1:0]  delta_nxt;
  logic [CFG_W-1:0]    mul_a;
  logic [PRICE_W-1:0]  mul_b;
  logic [PROD_W-1:0]   mul_res;
  logic [VPIN_W-1:0]   rem_nxt;
  logic [DIG-1:0]      qdig;

  // Weight saturates at full scale.
  assign alpha_sat = (alpha > SCALE_14) ? SCALE_14 : alpha;
  assign delta_nxt = (price >= prev_r) ? price - prev_r : prev_r - price;

  // One shared multiplier: new-delta term first, then the old average term.
  assign mul_a   = (state_r == E_MUL_A) ? alpha_r : beta_r;
  assign mul_b   = (state_r == E_MUL_A) ? delta_r : vol_r;
  assign mul_res = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Long division by 10000, four numerator bits per cycle on a narrow remainder.
  always_comb begin
    logic [VPIN_W:0]   t;
    logic [VPIN_W-1:0] r;
    r    = rem_r;
    qdig = '0;
    for (int i = 0; i < DIG; i++) begin
      t = {r, sh_r[SH_W-1-i]};
      if (t >= SCALE_15) begin
        t = t - SCALE_15;
        qdig[DIG-1-i] = 1'b1;
      end
      r = t[VPIN_W-1:0];
    end
    rem_nxt = r;
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      prev_r  <= '0;
      vol_r   <= '0;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        E_IDLE: begin
          if (start) begin
            // A trade with no previous price (prev_r zero) only records its price.
            if (prev_r != '0) begin
              state_r <= E_MUL_A;
            end
            prev_r  <= price;
            delta_r <= delta_nxt;
            alpha_r <= alpha_sat;
            beta_r  <= SCALE_14 - alpha_sat;
          end
        end
        E_MUL_A: begin
          prod_r  <= mul_res;
          state_r <= E_MUL_B;
        end
        E_MUL_B: begin
          acc_r   <= prod_r;
          prod_r  <= mul_res;
          state_r <= E_SUM;
        end
        E_SUM: begin
          sh_r    <= SH_W'(acc_r + prod_r);
          rem_r   <= '0;
          quo_r   <= '0;
          cnt_r   <= '0;
          state_r <= E_DIV;
        end
        E_DIV: begin
          sh_r  <= sh_r << DIG;
          rem_r <= rem_nxt;
          quo_r <= {quo_r[PRICE_W-DIG-1:0], qdig};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(STEPS - 1)) begin
            vol_r   <= {quo_r[PRICE_W-DIG-1:0], qdig};
            state_r <= E_IDLE;
          end
        end
        default: begin
          state_r <= E_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_r != E_IDLE);
  assign vol  = vol_r;

endmodule

`default_nettype wire

FILE: hw/rtl/vpt_dp.sv
// Datapath: trade ring, volume sums, VPIN and spread arithmetic, result register.
`default_nettype none

module vpt_dp #(
  parameter int unsigned WINDOW = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire vpt_pkg::vpt_cmd_t             cmd,
  output vpt_pkg::vpt_sts_t                  sts,
  input  wire vpt_pkg::vpt_cfg_t             cfg,
  input  wire logic                          in_trade_side,
  input  wire logic [vpt_pkg::QTY_W-1:0]     in_trade_qty,
  input  wire logic [vpt_pkg::PRICE_W-1:0]   in_trade_price,
  output logic [vpt_pkg::VPIN_W-1:0]         out_vpin_value,
  output logic                               out_toxic_flag,
  output logic [vpt_pkg::MULT_W-1:0]         out_spread_mult,
  output logic [vpt_pkg::PRICE_W-1:0]        out_volatility
);
  import vpt_pkg::*;

  localparam int unsigned PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W = QTY_W + PTR_W;
  localparam int unsigned NW    = SUM_W + VPIN_W;
  localparam int unsigned PR_W  = 2 * VPIN_W;

  // Latched request.
  logic                side_r;
  logic [QTY_W-1:0]    qty_r;
  logic [PRICE_W-1:0]  price_r;

  // Ring of past trades: side bit on top of the quantity.
  logic [QTY_W:0]      ring_mem [WINDOW];
  logic [QTY_W:0]      rd_r;
  logic [PTR_W-1:0]    ptr_r;
  logic                full_r;

  logic [SUM_W-1:0]    buy_r;
  logic [SUM_W-1:0]    sell_r;
  logic [SUM_W-1:0]    total_r;
  logic [SUM_W-1:0]    diff_r;
  logic                tot_zero_r;

  logic [NW-1:0]       num_r;
  logic [SUM_W-1:0]    den_r;
  logic [VPIN_W-1:0]   vpin_r;
  logic                toxic_r;

  logic [VPIN_W-1:0]   out_vpin_r;
  logic                out_toxic_r;
  logic [MULT_W-1:0]   out_mult_r;
  logic [PRICE_W-1:0]  out_vol_r;

  logic [SUM_W-1:0]    old_qty;
  logic [SUM_W-1:0]    new_qty;
  logic [PR_W-1:0]     num2;
  logic                div_busy;
  logic [VPIN_W-1:0]   div_q;
  logic                ema_busy;
  logic [PRICE_W-1:0]  ema_vol;

  assign old_qty = SUM_W'(rd_r[QTY_W-1:0]);
  assign new_qty = SUM_W'(qty_r);
  assign num2    = PR_W'(vpin_r - cfg.threshold) * PR_W'(SCALE_14);

  // Request capture.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      side_r  <= in_trade_side;
      qty_r   <= in_trade_qty;
      price_r <= in_trade_price;
    end
  end

  // Ring memory: one write port, one registered read at the write pointer.
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      ring_mem[ptr_r] <= {side_r, qty_r};
    end
    rd_r <= ring_mem[ptr_r];
  end

  // Pointer, fill state and running sums.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r   <= '0;
      full_r  <= 1'b0;
      buy_r   <= '0;
      sell_r  <= '0;
      total_r <= '0;
    end else if (cmd.evict) begin
      if (full_r) begin
        if (rd_r[QTY_W]) begin
          buy_r <= buy_r - old_qty;
        end else begin
          sell_r <= sell_r - old_qty;
        end
        total_r <= total_r - old_qty;
      end
    end else if (cmd.add) begin
      if (side_r) begin
        buy_r <= buy_r + new_qty;
      end else begin
        sell_r <= sell_r + new_qty;
      end
      total_r <= total_r + new_qty;
      if (ptr_r == PTR_W'(WINDOW - 1)) begin
        ptr_r  <= '0;
        full_r <= 1'b1;
      end else begin
        ptr_r <= ptr_r + 1'b1;
      end
    end
  end

  // VPIN and spread operands, toxic decision.
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      diff_r     <= (buy_r >= sell_r) ? buy_r - sell_r : sell_r - buy_r;
      tot_zero_r <= (total_r == '0);
    end
    if (cmd.scale) begin
      num_r <= NW'(diff_r) * NW'(SCALE_14);
      den_r <= total_r;
    end
    if (cmd.take_vpin) begin
      vpin_r <= tot_zero_r ? '0 : div_q;
    end
    if (cmd.num2) begin
      toxic_r <= cfg.enable && (vpin_r > cfg.threshold);
      num_r   <= NW'(num2);
      den_r   <= SUM_W'(SCALE_14 - cfg.threshold);
    end
  end

  vpt_div #(
    .NW (NW),
    .DW (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_r),
    .den   (den_r),
    .busy  (div_busy),
    .quot  (div_q)
  );

  vpt_ema u_ema (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.ema_start),
    .price (price_r),
    .alpha (cfg.alpha),
    .busy  (ema_busy),
    .vol   (ema_vol)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_vpin_r  <= vpin_r;
      out_toxic_r <= toxic_r;
      out_mult_r  <= toxic_r ? SCALE_15 + MULT_W'(div_q) : SCALE_15;
      out_vol_r   <= ema_vol;
    end
  end

  assign sts.div_idle = !div_busy;
  assign sts.ema_idle = !ema_busy;
  assign sts.toxic    = toxic_r;

  assign out_vpin_value  = out_vpin_r;
  assign out_toxic_flag  = out_toxic_r;
  assign out_spread_mult = out_mult_r;
  assign out_volatility  = out_vol_r;

  // The total is always the exact sum of the buy and sell sides.
  a_sum_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, total_r} == ({1'b0, buy_r} + {1'b0, sell_r})))
    else $error("total volume differs from buy plus sell");

  // A delivered VPIN never exceeds full scale.
  a_vpin_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (out_vpin_r <= SCALE_14))
    else $error("VPIN above full scale");

  // The multiplier departs from 10000 exactly when the flow is toxic, up to 20000.
  a_mult_toxic: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> ((out_toxic_r == (out_mult_r != SCALE_15)) &&
                      (out_mult_r <= MULT_MAX)))
    else $error("spread multiplier inconsistent with toxic flag");

endmodule

`default_nettype wire

FILE: hw/rtl/vpt_ctrl.sv
// Controller state machine that sequences one trade through the datapath.
`default_nettype none

module vpt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire vpt_pkg::vpt_sts_t  sts,
  output vpt_pkg::vpt_cmd_t       cmd
);
  import vpt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVICT,
    S_ADD,
    S_DIFF,
    S_SCALE,
    S_GO1,
    S_DIV1,
    S_VPIN,
    S_NUM2,
    S_CHK,
    S_DIV2,
    S_FIN
  } ctrl_state_t;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  // Command decode and next state.
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EVICT;
        end
      end
      S_EVICT: begin
        cmd.evict     = 1'b1;
        cmd.ema_start = 1'b1;
        state_nxt     = S_ADD;
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_GO1;
      end
      S_GO1: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV1;
      end
      S_DIV1: begin
        if (sts.div_idle) begin
          state_nxt = S_VPIN;
        end
      end
      S_VPIN: begin
        cmd.take_vpin = 1'b1;
        state_nxt     = S_NUM2;
      end
      S_NUM2: begin
        cmd.num2  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // Only toxic flow needs the spread division.
        if (sts.toxic) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV2;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV2: begin
        if (sts.div_idle) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.ema_idle && out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result valid: set on load, cleared when the result is taken.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // The divider is never restarted while it is still iterating.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> sts.div_idle)
    else $error("divider started while busy");

  // A result is only loaded once the volatility update has finished.
  a_ema_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.ema_idle)
    else $error("result loaded before volatility update finished");

  // The spread division runs only for toxic flow.
  a_div2_toxic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV2) |-> sts.toxic)
    else $error("spread division without toxic flow");

endmodule

`default_nettype wire

FILE: hw/rtl/vpin_toxicity_tracker.sv
// Top level: configuration registers, controller and datapath.
// A new request is accepted only once the previous one has reached the output register;
// toxic flow adds a second division, and one divider serves both divisions. A finished
// result waits in the output register while the next trade is processed.
// Reset (synchronous, rst_n low) clears sums, pointers and EMA state and restores register
// defaults; ring contents are not cleared since an entry is read only after it is written.
`default_nettype none

module vpin_toxicity_tracker #(
  parameter int unsigned WINDOW = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_trade_side,
  input  wire logic [vpt_pkg::QTY_W-1:0]     in_trade_qty,
  input  wire logic [vpt_pkg::PRICE_W-1:0]   in_trade_price,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [vpt_pkg::VPIN_W-1:0]         out_vpin_value,
  output logic                               out_toxic_flag,
  output logic [vpt_pkg::MULT_W-1:0]         out_spread_mult,
  output logic [vpt_pkg::PRICE_W-1:0]        out_volatility,
  input  wire logic                          cfg_we,
  input  wire logic [vpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vpt_pkg::CFG_W-1:0]     cfg_wdata
);
  import vpt_pkg::*;

  vpt_cfg_t cfg_r;
  vpt_cmd_t cmd;
  vpt_sts_t sts;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable    <= 1'b0;
      cfg_r.threshold <= THR_RST;
      cfg_r.alpha     <= ALPHA_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:    cfg_r.enable    <= cfg_wdata[0];
        CFG_THRESHOLD: cfg_r.threshold <= cfg_wdata;
        CFG_ALPHA:     cfg_r.alpha     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  vpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vpt_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg             (cfg_r),
    .in_trade_side   (in_trade_side),
    .in_trade_qty    (in_trade_qty),
    .in_trade_price  (in_trade_price),
    .out_vpin_value  (out_vpin_value),
    .out_toxic_flag  (out_toxic_flag),
    .out_spread_mult (out_spread_mult),
    .out_volatility  (out_volatility)
  );

endmodule

`default_nettype wire

FILE: tb/sv/vpin_toxicity_tracker_tb.sv
// Self-checking testbench for the VPIN toxicity tracker with a built-in trade predictor.
`timescale 1ns / 1ps

module vpin_toxicity_tracker_tb;
  import vpt_pkg::*;

  localparam int unsigned TRADE_WINDOW = 256;
  localparam int unsigned HIST_W       = $clog2(TRADE_WINDOW);
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [63:0] BPS = 64'd10000;
  localparam logic [PRICE_W-1:0] PRICE_TOP = 48'hFFFF_FFFF_FFFF;

  // One trade request and one tracker result.
  typedef struct packed {
    logic               side;
    logic [QTY_W-1:0]   qty;
    logic [PRICE_W-1:0] price;
  } trade_t;

  typedef struct packed {
    logic [VPIN_W-1:0]  vpin_value;
    logic               toxic_flag;
    logic [MULT_W-1:0]  spread_mult;
    logic [PRICE_W-1:0] volatility;
  } metrics_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_trade_side = 1'b0;
  logic [QTY_W-1:0]     in_trade_qty = '0;
  logic [PRICE_W-1:0]   in_trade_price = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [VPIN_W-1:0]    out_vpin_value;
  logic                 out_toxic_flag;
  logic [MULT_W-1:0]    out_spread_mult;
  logic [PRICE_W-1:0]   out_volatility;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  vpin_toxicity_tracker #(
    .WINDOW(TRADE_WINDOW)
  ) i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_trade_side  (in_trade_side),
    .in_trade_qty   (in_trade_qty),
    .in_trade_price (in_trade_price),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_vpin_value (out_vpin_value),
    .out_toxic_flag (out_toxic_flag),
    .out_spread_mult(out_spread_mult),
    .out_volatility (out_volatility),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Predictor state: trade ring, volume sums, price history and registers.
  logic [QTY_W-1:0]   qty_hist [TRADE_WINDOW];
  logic               side_hist [TRADE_WINDOW];
  logic [HIST_W-1:0]  hist_slot = '0;
  int unsigned        hist_fill = 0;
  logic [63:0]        buy_qty_sum = '0;
  logic [63:0]        sell_qty_sum = '0;
  logic [63:0]        all_qty_sum = '0;
  logic [PRICE_W-1:0] prior_price = '0;
  logic [PRICE_W-1:0] vol_ema = '0;
  logic               cfg_enable = 1'b0;
  logic [CFG_W-1:0]   cfg_threshold = THR_RST;
  logic [CFG_W-1:0]   cfg_alpha = ALPHA_RST;

  // Stimulus and scoreboard bookkeeping.
  trade_t             pending_trades[$];
  metrics_t           predicted_metrics[$];
  trade_t             cur_trade;
  metrics_t           want_metrics;
  logic [PRICE_W-1:0] walk_price = '0;
  int unsigned        send_wait = 0;
  int unsigned        ready_wait = 0;
  int unsigned        hold_left = 0;
  int unsigned        stall_burst = 0;
  bit                 calm = 1'b0;
  int unsigned        trades_sent = 0;
  int unsigned        results_seen = 0;
  int unsigned        toxic_seen = 0;
  int unsigned        error_count = 0;
  int unsigned        cycle_count = 0;

  // Apply one trade to the predictor and return the result it must produce.
  function automatic metrics_t predict_trade(trade_t t);
    metrics_t    r;
    logic [63:0] old_qty;
    logic [63:0] diff;
    logic [63:0] vp;
    logic [63:0] delta;
    logic [63:0] weight;
    logic [63:0] thr;
    logic [63:0] mult;
    logic [63:0] ema_next;
    if (hist_fill == TRADE_WINDOW) begin
      old_qty = 64'(qty_hist[hist_slot]);
      if (side_hist[hist_slot]) begin
        buy_qty_sum -= old_qty;
      end else begin
        sell_qty_sum -= old_qty;
      end
      all_qty_sum -= old_qty;
    end
    qty_hist[hist_slot]  = t.qty;
    side_hist[hist_slot] = t.side;
    if (t.side) begin
      buy_qty_sum += 64'(t.qty);
    end else begin
      sell_qty_sum += 64'(t.qty);
    end
    all_qty_sum += 64'(t.qty);
    hist_slot = (hist_slot == HIST_W'(TRADE_WINDOW - 1)) ? '0 : hist_slot + 1'b1;
    if (hist_fill < TRADE_WINDOW) begin
      hist_fill++;
    end

    // The EMA is held while there is no previous price.
    if (prior_price != '0) begin
      delta    = (t.price >= prior_price) ? 64'(t.price - prior_price)
                                          : 64'(prior_price - t.price);
      weight   = (64'(cfg_alpha) > BPS) ? BPS : 64'(cfg_alpha);
      ema_next = (weight * delta + (BPS - weight) * 64'(vol_ema)) / BPS;
      vol_ema  = ema_next[PRICE_W-1:0];
    end
    prior_price = t.price;

    diff = (buy_qty_sum >= sell_qty_sum) ? buy_qty_sum - sell_qty_sum
                                         : sell_qty_sum - buy_qty_sum;
    vp   = (all_qty_sum == '0) ? '0 : diff * BPS / all_qty_sum;
    thr  = 64'(cfg_threshold);
    r.vpin_value  = vp[VPIN_W-1:0];
    r.toxic_flag  = 1'b0;
    r.spread_mult = SCALE_15;
    r.volatility  = vol_ema;
    if (cfg_enable && vp > thr) begin
      mult          = BPS + (vp - thr) * BPS / (BPS - thr);
      r.toxic_flag  = 1'b1;
      r.spread_mult = mult[MULT_W-1:0];
    end
    return r;
  endfunction

  // Per-request wait for either side; zero throughout a calm phase.
  function automatic int unsigned draw_wait();
    if (calm || $urandom_range(0, 2) == 0) begin
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  // Prices mostly walk in small steps, with jumps and zero prices mixed in.
  function automatic logic [PRICE_W-1:0] next_price();
    logic [63:0] wide;
    int unsigned pick;
    int unsigned step;
    wide = {$urandom, $urandom};
    pick = $urandom_range(0, 99);
    step = $urandom_range(0, 3000);
    if (pick < 5) begin
      return '0;
    end
    if (pick < 12 || walk_price == '0) begin
      walk_price = wide[PRICE_W-1:0];
    end else if (pick < 55 && walk_price > PRICE_W'(step)) begin
      walk_price -= PRICE_W'(step);
    end else begin
      walk_price += PRICE_W'(step);
    end
    return walk_price;
  endfunction

  task automatic report_error(string msg);
    error_count++;
    $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  task automatic compare_field(string field, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      report_error($sformatf("result %0d %s: got %0d, expected %0d",
                             results_seen, field, got, want));
    end
  endtask

  // Register write at a rising edge; the caller lowers the write enable.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_ENABLE:    cfg_enable = val[0];
      CFG_THRESHOLD: cfg_threshold = val;
      CFG_ALPHA:     cfg_alpha = val;
      default:       ;
    endcase
  endtask

  task automatic configure(logic en, logic [CFG_W-1:0] thr, logic [CFG_W-1:0] alpha);
    write_reg(CFG_ENABLE, {{(CFG_W-1){1'b0}}, en});
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_ALPHA, alpha);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_trade(logic side, logic [QTY_W-1:0] qty, logic [PRICE_W-1:0] price);
    trade_t t;
    t.side  = side;
    t.qty   = qty;
    t.price = price;
    pending_trades.push_back(t);
  endtask

  // Wait until the sender is empty and every predicted result has been checked.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_trades.size() != 0 || in_valid || predicted_metrics.size() != 0);
  endtask

  // Queue a batch of random trades with a given buy share, then let it drain.
  task automatic run_trades(int unsigned count, int unsigned buy_pct, bit zero_sells);
    logic               side;
    logic [QTY_W-1:0]   qty;
    @(negedge clk);
    for (int unsigned i = 0; i < count; i++) begin
      side = ($urandom_range(0, 99) < buy_pct);
      case ($urandom_range(0, 9))
        0:       qty = '0;
        1, 2:    qty = $urandom;
        default: qty = $urandom_range(1, 5000);
      endcase
      if (zero_sells && !side) begin
        qty = '0;
      end
      queue_trade(side, qty, next_price());
    end
    wait_drained();
  endtask

  // Trade driver: predicts each accepted request and offers the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_metrics.push_back(predict_trade(cur_trade));
        trades_sent++;
        send_wait = draw_wait();
      end
      if (!in_valid || in_ready) begin
        if (send_wait != 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_trades.size() != 0) begin
          cur_trade = pending_trades.pop_front();
          in_valid       <= 1'b1;
          in_trade_side  <= cur_trade.side;
          in_trade_qty   <= cur_trade.qty;
          in_trade_price <= cur_trade.price;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted result and paces out_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_metrics.size() == 0) begin
          report_error("result arrived with no request outstanding");
        end else begin
          want_metrics = predicted_metrics.pop_front();
          compare_field("vpin_value", 64'(out_vpin_value), 64'(want_metrics.vpin_value));
          compare_field("toxic_flag", 64'(out_toxic_flag), 64'(want_metrics.toxic_flag));
          compare_field("spread_mult", 64'(out_spread_mult),
                        64'(want_metrics.spread_mult));
          compare_field("volatility", 64'(out_volatility), 64'(want_metrics.volatility));
        end
        results_seen++;
        if (out_toxic_flag) begin
          toxic_seen++;
        end
        ready_wait = draw_wait();
      end
      if (stall_burst != 0) begin
        hold_left   = stall_burst;
        stall_burst = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (ready_wait != 0) begin
        ready_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending.",
               cycle_count, predicted_metrics.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset settings: empty and zero-quantity windows, zero and extreme prices.
    queue_trade(1'b1, '0, '0);
    queue_trade(1'b0, '0, 48'd100);
    queue_trade(1'b1, 32'hFFFF_FFFF, PRICE_TOP);
    queue_trade(1'b0, 32'hFFFF_FFFF, 48'd1);
    queue_trade(1'b1, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA);
    queue_trade(1'b0, 32'h5555_5555, 48'h5555_5555_5555);
    wait_drained();

    // Full alpha, mid threshold; the unused index must be ignored.
    write_reg(CFG_SPARE, 14'h3FFF);
    configure(1'b1, 14'd5000, 14'd10000);
    @(negedge clk);
    queue_trade(1'b1, 32'd1, '0);
    queue_trade(1'b0, 32'd5, 48'd1000);
    queue_trade(1'b1, 32'hFFFF_FFFF, 48'd1500);
    queue_trade(1'b1, 32'hFFFF_FFFF, 48'd1400);
    queue_trade(1'b1, 32'hFFFF_FFFF, 48'd1600);
    queue_trade(1'b1, 32'hFFFF_FFFF, PRICE_TOP);
    queue_trade(1'b0, 32'd7, 48'hFFFF_FFFF_FFFE);
    queue_trade(1'b0, 32'hFFFF_FFFF, 48'd2);
    queue_trade(1'b1, '0, 48'd3);
    queue_trade(1'b0, 32'h8000_0000, 48'h8000_0000_0000);
    queue_trade(1'b1, 32'h0000_FFFF, 48'h0000_FFFF_FFFF);
    queue_trade(1'b0, 32'h0000_0001, '0);
    wait_drained();

    // Zero threshold and zero alpha; results held off long enough to stall input.
    configure(1'b1, 14'd0, 14'd0);
    stall_burst = 400;
    run_trades(70, 60, 1'b0);

    // Top threshold with saturated alpha; only pure buy flow turns toxic here.
    configure(1'b1, 14'd9999, 14'h3FFF);
    calm = 1'b1;
    run_trades(60, 70, 1'b1);
    calm = 1'b0;

    // Tracking disabled with a low threshold.
    configure(1'b0, 14'd2000, 14'd500);
    run_trades(60, 85, 1'b0);

    // Threshold past full scale can never trip; alpha just above full scale.
    configure(1'b1, 14'h3FFF, 14'd10001);
    run_trades(60, 50, 1'b0);

    // Default settings, enabled, with buy-heavy flow.
    configure(1'b1, THR_RST, ALPHA_RST);
    run_trades(80, 80, 1'b0);

    configure(1'b1, 14'd3000, 14'd9999);
    run_trades(70, 65, 1'b0);

    repeat (60) @(posedge clk);
    $display("Ran %0d trades through eight register settings, wrapping the window.",
             trades_sent);
    $display("Checked %0d results, %0d toxic; %0d mismatches.",
             results_seen, toxic_seen, error_count);
    if (error_count == 0 && predicted_metrics.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
